@@ sv/wfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wfsp_pkg
// Types and constants shared by the fragment size planner modules.
// ----------------------------------------------------------------------------
package wfsp_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [15:0] THR_RESET  = 16'd2346;
	localparam logic [7:0]  MGMT_RESET = 8'd24;

	// register index, taken from paddr[2]
	localparam logic REG_THR  = 1'b0;
	localparam logic REG_MGMT = 1'b1;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_MGMT = 2'd1;

	typedef enum logic [2:0] {
		STAT_NONE         = 3'd0,
		STAT_FRAG         = 3'd1,
		STAT_NOT_ELIGIBLE = 3'd2,
		STAT_NO_ROOM      = 3'd3,
		STAT_NO_EVEN      = 3'd4,
		STAT_TOO_MANY     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_MUL,
		S_DECIDE,
		S_FRAG
	} state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic mul;
		logic emit_status;
		logic emit_frag;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic is_frag;
		logic frag_last;
	} dp_stat_t;

endpackage

@@ sv/wfsp_in_if.sv @@
// ----------------------------------------------------------------------------
// wfsp_in_if
// Frame descriptor channel: valid/ready handshake with descriptor payload.
// ----------------------------------------------------------------------------
interface wfsp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] frame_length;
	logic [1:0]  header_kind;
	logic        receiver_multicast;
	logic [7:0]  data_header_length;
	logic [7:0]  trailer_length;

	modport source (
		output valid, frame_length, header_kind, receiver_multicast,
		       data_header_length, trailer_length,
		input  ready
	);
	modport sink (
		input  valid, frame_length, header_kind, receiver_multicast,
		       data_header_length, trailer_length,
		output ready
	);
endinterface

@@ sv/wfsp_out_if.sv @@
// ----------------------------------------------------------------------------
// wfsp_out_if
// Fragment result channel: valid/ready handshake with size, status, last.
// ----------------------------------------------------------------------------
interface wfsp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] fragment_size;
	logic [2:0]  status;
	logic        last;

	modport source (
		output valid, fragment_size, status, last,
		input  ready
	);
	modport sink (
		input  valid, fragment_size, status, last,
		output ready
	);
endinterface

@@ sv/wfsp_regs.sv @@
// ----------------------------------------------------------------------------
// wfsp_regs
// APB configuration registers: fragmentation threshold and management
// header length.
// ----------------------------------------------------------------------------
module wfsp_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wfsp_pkg::ADDR_W-1:0] paddr,
	input  logic [wfsp_pkg::DATA_W-1:0] pwdata,
	output logic [wfsp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [15:0]                 thr,
	output logic [7:0]                  mgmt_hdr
);
	import wfsp_pkg::*;

	logic [15:0] thr_q;
	logic [7:0]  mgmt_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			mgmt_q <= MGMT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_THR:  thr_q  <= pwdata[15:0];
				REG_MGMT: mgmt_q <= pwdata[7:0];
				default:  thr_q  <= thr_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THR:  prdata = {16'd0, thr_q};
			REG_MGMT: prdata = {24'd0, mgmt_q};
			default:  prdata = '0;
		endcase
	end

	assign thr      = thr_q;
	assign mgmt_hdr = mgmt_q;

endmodule

@@ sv/wfsp_dp.sv @@
// ----------------------------------------------------------------------------
// wfsp_dp
// Datapath: descriptor capture, overhead and body size arithmetic, fragment
// limit product, remaining payload counter and the result register.
// ----------------------------------------------------------------------------
module wfsp_dp #(
	parameter int MAX_FRAGMENTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wfsp_pkg::dp_cmd_t cmd,
	output wfsp_pkg::dp_stat_t stat,
	input  logic [15:0]       thr,
	input  logic [7:0]        mgmt_hdr,
	input  logic [15:0]       frame_length,
	input  logic [1:0]        header_kind,
	input  logic              receiver_multicast,
	input  logic [7:0]        data_header_length,
	input  logic [7:0]        trailer_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       fragment_size,
	output logic [2:0]        status,
	output logic              last
);
	import wfsp_pkg::*;

	localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);
	localparam int PROD_W = 16 + CNT_W;

	// captured descriptor
	logic [15:0] flen_q;
	logic [1:0]  kind_q;
	logic        mcast_q;
	logic [7:0]  dhdr_q;
	logic [7:0]  trl_q;

	// derived quantities
	logic [7:0]        hdr_c;
	logic [8:0]        ovh_c;
	logic [15:0]       ovh16_c;
	logic [15:0]       payload_c;
	logic [15:0]       maxbody_c;
	logic              short_c, inelig_c, no_room_c;
	logic [15:0]       payload_q;
	logic [15:0]       maxbody_q;
	logic              short_q, inelig_q, no_room_q;
	logic [PROD_W-1:0] limit_q;

	status_t     code_c;
	logic [15:0] sz_c;
	logic        frag_last_c;

	logic        out_valid_q;
	logic [15:0] size_q;
	status_t     status_q;
	logic        last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flen_q  <= frame_length;
			kind_q  <= header_kind;
			mcast_q <= receiver_multicast;
			dhdr_q  <= data_header_length;
			trl_q   <= trailer_length;
		end
	end

	always_comb begin
		hdr_c     = (kind_q == KIND_MGMT) ? mgmt_hdr : dhdr_q;
		ovh_c     = {1'b0, hdr_c} + {1'b0, trl_q};
		ovh16_c   = {7'd0, ovh_c};
		// saturate to zero when header and trailer exceed the frame
		payload_c = (flen_q > ovh16_c) ? (flen_q - ovh16_c) : 16'd0;
		no_room_c = (thr <= ovh16_c);
		maxbody_c = (thr - ovh16_c) & ~16'd1;
		short_c   = (thr >= flen_q);
		inelig_c  = mcast_q || ((kind_q != KIND_DATA) && (kind_q != KIND_MGMT));
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			payload_q <= payload_c;
			maxbody_q <= maxbody_c;
			short_q   <= short_c;
			inelig_q  <= inelig_c;
			no_room_q <= no_room_c;
		end else if (cmd.emit_frag) begin
			payload_q <= payload_q - sz_c;
		end
		if (cmd.mul) begin
			limit_q <= PROD_W'(maxbody_q) * PROD_W'(MAX_FRAGMENTS);
		end
	end

	always_comb begin
		if (short_q)                          code_c = STAT_NONE;
		else if (inelig_q)                    code_c = STAT_NOT_ELIGIBLE;
		else if (no_room_q)                   code_c = STAT_NO_ROOM;
		else if (maxbody_q == 16'd0)          code_c = STAT_NO_EVEN;
		else if (PROD_W'(payload_q) > limit_q) code_c = STAT_TOO_MANY;
		else if (payload_q == 16'd0)          code_c = STAT_NONE;
		else                                  code_c = STAT_FRAG;
	end

	assign sz_c        = (payload_q > maxbody_q) ? maxbody_q : payload_q;
	assign frag_last_c = (payload_q <= maxbody_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_status || cmd.emit_frag) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_status) begin
			size_q   <= 16'd0;
			status_q <= code_c;
			last_q   <= 1'b1;
		end else if (cmd.emit_frag) begin
			size_q   <= sz_c;
			status_q <= STAT_FRAG;
			last_q   <= frag_last_c;
		end
	end

	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.is_frag   = (code_c == STAT_FRAG);
	assign stat.frag_last = frag_last_c;

	assign out_valid     = out_valid_q;
	assign fragment_size = size_q;
	assign status        = status_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_status || cmd.emit_frag) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while full");
	a_frag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_frag |-> (sz_c != 16'd0))
		else $error("empty fragment emitted");
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_status |=> (last_q && (size_q == 16'd0) && (status_q != STAT_FRAG)))
		else $error("status result malformed");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_frag && frag_last_c) |=> (payload_q == 16'd0))
		else $error("payload left after last fragment");
`endif

endmodule

@@ sv/wfsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// wfsp_ctrl
// Controller: sequences capture, arithmetic, decision and fragment emission.
// ----------------------------------------------------------------------------
module wfsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output wfsp_pkg::dp_cmd_t  cmd,
	input  wfsp_pkg::dp_stat_t stat
);
	import wfsp_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.is_frag) begin
					state_nxt = S_FRAG;
				end else if (stat.slot_free) begin
					cmd.emit_status = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			S_FRAG: begin
				if (stat.slot_free) begin
					cmd.emit_frag = 1'b1;
					if (stat.frag_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/wlan_fragment_size_planner.sv @@
// ----------------------------------------------------------------------------
// wlan_fragment_size_planner
// Splits one frame descriptor into fragment body sizes, or a single status.
// ----------------------------------------------------------------------------
// Sequence: after a descriptor is accepted the controller steps through
// S_CALC, S_MUL and S_DECIDE; a status result is registered from S_DECIDE,
// fragments from S_FRAG at one per cycle while the receiver takes the output.
// A new descriptor is accepted only once the last result has been registered.
// Reset: arst_n clears the FSM and result valid; the threshold returns to
// 2346 and the management header length to 24.
// ----------------------------------------------------------------------------
module wlan_fragment_size_planner #(
	parameter int MAX_FRAGMENTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wfsp_pkg::ADDR_W-1:0] paddr,
	input  logic [wfsp_pkg::DATA_W-1:0] pwdata,
	output logic [wfsp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	wfsp_in_if.sink                     frame_in,
	wfsp_out_if.source                  plan_out
);
	import wfsp_pkg::*;

	logic [15:0] thr;
	logic [7:0]  mgmt_hdr;
	logic        in_ready;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	wfsp_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.thr      (thr),
		.mgmt_hdr (mgmt_hdr)
	);

	wfsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_in.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	wfsp_dp #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.thr                (thr),
		.mgmt_hdr           (mgmt_hdr),
		.frame_length       (frame_in.frame_length),
		.header_kind        (frame_in.header_kind),
		.receiver_multicast (frame_in.receiver_multicast),
		.data_header_length (frame_in.data_header_length),
		.trailer_length     (frame_in.trailer_length),
		.out_valid          (plan_out.valid),
		.out_ready          (plan_out.ready),
		.fragment_size      (plan_out.fragment_size),
		.status             (plan_out.status),
		.last               (plan_out.last)
	);

	assign frame_in.ready = in_ready;

endmodule
